FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bee_pkg.sv
`timescale 1ns / 1ps

package bee_pkg;

    // Histogram geometry.
    localparam int NUM_BINS   = 256;
    localparam int BIN_AW     = 8;

    // Extra fractional bits carried through the log and sum.
    localparam int GUARD_BITS = 8;

    // Mantissa width of the log2 squaring unit.
    localparam int MANT_W     = 32;

    // floor(ln2 * 2^32).
    localparam logic [MANT_W-1:0] LN2_Q32 = 32'hB17217F7;

    // Main sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_LOGN,
        ST_LOGN_W,
        ST_RD,
        ST_CHK,
        ST_LOGF_W,
        ST_DIFF,
        ST_MUL,
        ST_DIVS,
        ST_DIV,
        ST_LN2,
        ST_ROUND,
        ST_EMIT
    } st_t;

    // Log2 unit states.
    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_SQ
    } log_st_t;

    // Status of the log2 unit seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } log_stat_t;

endpackage

FILE: hdl/bee_ram.sv
`timescale 1ns / 1ps

module bee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/bee_log2.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bee_log2 #(
    parameter int CW = 32,
    parameter int WF = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [CW-1:0]                 x,
    output bee_pkg::log_stat_t            stat,
    output logic [$clog2(CW)+WF-1:0]      result
);

    localparam int KW   = $clog2(CW);
    localparam int MW   = bee_pkg::MANT_W;
    localparam int CNTW = $clog2(WF);

    bee_pkg::log_st_t lst_reg, lst_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    xs_reg, xs_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [MW-1:0]    m_reg, m_next;
    logic [WF-1:0]    frac_reg, frac_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;

    logic [CW+MW-1:0] ext;
    logic [2*MW-1:0]  prod;
    logic [MW:0]      sq;
    logic             last_sq;

    // The normalized word, padded so its top bits form the mantissa.
    assign ext     = {xs_reg, {MW{1'b0}}};
    assign prod    = m_reg * m_reg;
    assign sq      = prod[2*MW-1:MW-1];
    assign last_sq = (cnt_reg == CNTW'(WF - 1));

    // Next state.
    always_comb
    begin
        lst_next = lst_reg;
        case (lst_reg)
            bee_pkg::L_IDLE:
            begin
                if (start)
                begin
                    lst_next = bee_pkg::L_NORM;
                end
            end
            bee_pkg::L_NORM:
            begin
                if (xs_reg[CW-1])
                begin
                    lst_next = bee_pkg::L_SQ;
                end
            end
            bee_pkg::L_SQ:
            begin
                if (last_sq)
                begin
                    lst_next = bee_pkg::L_IDLE;
                end
            end
            default:
            begin
                lst_next = bee_pkg::L_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        stat.busy = (lst_reg != bee_pkg::L_IDLE);
        stat.done = done_reg;
        result    = {k_reg, frac_reg};
    end

    // Datapath: normalize by bytes then bits, then square once per result bit.
    always_comb
    begin
        xs_next   = xs_reg;
        k_next    = k_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (lst_reg)
            bee_pkg::L_IDLE:
            begin
                if (start)
                begin
                    xs_next = x;
                    k_next  = KW'(CW - 1);
                end
            end
            bee_pkg::L_NORM:
            begin
                if (xs_reg[CW-1])
                begin
                    m_next   = ext[CW+MW-1 -: MW];
                    cnt_next = '0;
                end
                else if (xs_reg[CW-1 -: 8] == 8'd0)
                begin
                    xs_next = xs_reg << 8;
                    k_next  = k_reg - KW'(8);
                end
                else
                begin
                    xs_next = xs_reg << 1;
                    k_next  = k_reg - KW'(1);
                end
            end
            bee_pkg::L_SQ:
            begin
                if (sq[MW])
                begin
                    m_next    = sq[MW:1];
                    frac_next = {frac_reg[WF-2:0], 1'b1};
                end
                else
                begin
                    m_next    = sq[MW-1:0];
                    frac_next = {frac_reg[WF-2:0], 1'b0};
                end
                cnt_next  = cnt_reg + CNTW'(1);
                done_next = last_sq;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lst_reg  <= bee_pkg::L_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            lst_reg  <= lst_next;
            done_reg <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        xs_reg   <= xs_next;
        k_reg    <= k_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
    end

    `ASSERT_IMP(a_start_idle, clk, rst_n, start, !stat.busy, "log2 started while busy")
    `ASSERT_IMP(a_mant_norm, clk, rst_n, lst_reg == bee_pkg::L_SQ, m_reg[MW-1], "mantissa not normalized")
    `ASSERT_NXT(a_done_pulse, clk, rst_n, stat.done, !stat.done, "log2 done held too long")

endmodule

FILE: hdl/byte_entropy_estimator.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel | Direction | Handshake           | Fields
// input   | in        | in_valid, in_stall  | byte_value, clear_first, report_after
// output  | out       | out_valid, out_stall| entropy_nats, bytes_counted, count_saturated
//
// A word without a report is accepted with its bin read, then its bin is written.
// A report first takes log2 of the total, then walks all 256 bins: an empty bin is
// read and checked, and a nonzero bin passes the log2 unit (normalize, then squaring),
// a difference and shift-adds on the shared adder; then a division and an ln2
// multiply, both on that same adder.
// Reset clears the histogram valid bits at once; no clearing pass is needed.
// in_stall is high whenever a word is in work; a report waits on a full output.
module byte_entropy_estimator #(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             byte_value,
    input  logic                   clear_first,
    input  logic                   report_after,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FRAC_BITS+2:0]   entropy_nats,
    output logic [COUNT_WIDTH-1:0] bytes_counted,
    output logic                   count_saturated
);

    localparam int CW   = COUNT_WIDTH;
    localparam int NB   = bee_pkg::NUM_BINS;
    localparam int BAW  = bee_pkg::BIN_AW;
    localparam int WF   = FRAC_BITS + bee_pkg::GUARD_BITS;
    localparam int KW   = $clog2(CW);
    localparam int DW   = KW + WF;
    localparam int QW   = WF + 8;
    localparam int SW   = CW + 8 + DW;
    localparam int PW   = QW + bee_pkg::MANT_W;
    localparam int AW   = (SW > PW) ? SW : PW;
    localparam int CNTW = $clog2(QW);
    localparam int EW   = FRAC_BITS + 3;
    localparam int RSH  = bee_pkg::MANT_W + bee_pkg::GUARD_BITS;
    localparam int EHW  = AW - RSH;
    localparam logic [CW-1:0]  COUNT_MAX = {CW{1'b1}};
    localparam logic [EHW-1:0] ENT_MAX   = (EHW'(1) << EW) - EHW'(1);
    localparam logic [AW-1:0]  RND       = AW'(1) << (RSH - 1);

    bee_pkg::st_t      state_reg, state_next;
    logic [7:0]        byte_reg, byte_next;
    logic              rpt_reg, rpt_next;
    logic [NB-1:0]     vld_reg, vld_next;
    logic [CW-1:0]     total_reg, total_next;
    logic              sat_reg, sat_next;
    logic [AW-1:0]     s_reg, s_next;
    logic [AW-1:0]     opd_reg, opd_next;
    logic [QW-1:0]     mbits_reg, mbits_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     logn_reg, logn_next;
    logic [BAW-1:0]    bin_reg, bin_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic              ovld_reg, ovld_next;
    logic [EW-1:0]     oent_reg, oent_next;
    logic [CW-1:0]     ocnt_reg, ocnt_next;
    logic              osat_reg, osat_next;

    logic              ram_we;
    logic [BAW-1:0]    ram_waddr;
    logic [CW-1:0]     ram_wdata;
    logic [BAW-1:0]    ram_raddr;
    logic [CW-1:0]     ram_rdata;

    logic              log_start;
    logic [CW-1:0]     log_x;
    bee_pkg::log_stat_t log_stat;
    logic [DW-1:0]     log_res;

    logic [AW-1:0]     alu_a, alu_b;
    logic              alu_sub;
    logic [AW:0]       alu_sum;

    logic              in_acc;
    logic              out_free;
    logic [BAW-1:0]    rd_idx;
    logic [CW-1:0]     rd_f;
    logic [CW-1:0]     f_clamp;
    logic              last_bin;
    logic [CW:0]       div_t;
    logic [CW-1:0]     base_total;
    logic [EHW-1:0]    ent_hi;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !ovld_reg || !out_stall;
    assign in_stall = (state_reg != bee_pkg::ST_IDLE);
    assign last_bin = (bin_reg == BAW'(NB - 1));

    // Bin value as read: an entry not written since the last clear counts zero.
    assign rd_idx  = (state_reg == bee_pkg::ST_UPD) ? byte_reg : bin_reg;
    assign rd_f    = vld_reg[rd_idx] ? ram_rdata : '0;
    assign f_clamp = (rd_f > total_reg) ? total_reg : rd_f;

    assign div_t      = {rem_reg, s_reg[QW-1]};
    assign base_total = clear_first ? '0 : total_reg;
    assign ent_hi     = s_reg[AW-1:RSH];

    // Shared adder-subtractor.
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);

    bee_ram #(
        .WIDTH (CW),
        .DEPTH (NB)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bee_log2 #(
        .CW (CW),
        .WF (WF)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .stat   (log_stat),
        .result (log_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bee_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = bee_pkg::ST_UPD;
                end
            end
            bee_pkg::ST_UPD:
            begin
                state_next = rpt_reg ? bee_pkg::ST_LOGN : bee_pkg::ST_IDLE;
            end
            bee_pkg::ST_LOGN:
            begin
                state_next = bee_pkg::ST_LOGN_W;
            end
            bee_pkg::ST_LOGN_W:
            begin
                if (log_stat.done)
                begin
                    state_next = bee_pkg::ST_RD;
                end
            end
            bee_pkg::ST_RD:
            begin
                state_next = bee_pkg::ST_CHK;
            end
            bee_pkg::ST_CHK:
            begin
                if (rd_f != '0)
                begin
                    state_next = bee_pkg::ST_LOGF_W;
                end
                else
                begin
                    state_next = last_bin ? bee_pkg::ST_DIVS : bee_pkg::ST_RD;
                end
            end
            bee_pkg::ST_LOGF_W:
            begin
                if (log_stat.done)
                begin
                    state_next = bee_pkg::ST_DIFF;
                end
            end
            bee_pkg::ST_DIFF:
            begin
                state_next = bee_pkg::ST_MUL;
            end
            bee_pkg::ST_MUL:
            begin
                if (cnt_reg == CNTW'(DW - 1))
                begin
                    state_next = last_bin ? bee_pkg::ST_DIVS : bee_pkg::ST_RD;
                end
            end
            bee_pkg::ST_DIVS:
            begin
                state_next = bee_pkg::ST_DIV;
            end
            bee_pkg::ST_DIV:
            begin
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    state_next = bee_pkg::ST_LN2;
                end
            end
            bee_pkg::ST_LN2:
            begin
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    state_next = bee_pkg::ST_ROUND;
                end
            end
            bee_pkg::ST_ROUND:
            begin
                state_next = bee_pkg::ST_EMIT;
            end
            bee_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = bee_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bee_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs: memory, log2 unit and shared adder operands.
    always_comb
    begin
        ram_raddr = bin_reg;
        ram_we    = 1'b0;
        ram_waddr = byte_reg;
        ram_wdata = rd_f + CW'(1);
        log_start = 1'b0;
        log_x     = f_clamp;
        alu_a     = s_reg;
        alu_b     = opd_reg;
        alu_sub   = 1'b0;
        case (state_reg)
            bee_pkg::ST_IDLE:
            begin
                ram_raddr = byte_value;
            end
            bee_pkg::ST_UPD:
            begin
                ram_we = (rd_f != COUNT_MAX);
            end
            bee_pkg::ST_LOGN:
            begin
                log_start = 1'b1;
                log_x     = total_reg;
            end
            bee_pkg::ST_CHK:
            begin
                log_start = (rd_f != '0);
            end
            bee_pkg::ST_DIFF:
            begin
                alu_a   = AW'(logn_reg);
                alu_b   = AW'(log_res);
                alu_sub = 1'b1;
            end
            bee_pkg::ST_DIV:
            begin
                alu_a   = AW'(div_t);
                alu_b   = AW'(total_reg);
                alu_sub = 1'b1;
            end
            bee_pkg::ST_ROUND:
            begin
                alu_b = RND;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        byte_next  = byte_reg;
        rpt_next   = rpt_reg;
        vld_next   = vld_reg;
        total_next = total_reg;
        sat_next   = sat_reg;
        s_next     = s_reg;
        opd_next   = opd_reg;
        mbits_next = mbits_reg;
        rem_next   = rem_reg;
        logn_next  = logn_reg;
        bin_next   = bin_reg;
        cnt_next   = cnt_reg;
        ovld_next  = ovld_reg && out_stall;
        oent_next  = oent_reg;
        ocnt_next  = ocnt_reg;
        osat_next  = osat_reg;
        case (state_reg)
            bee_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    byte_next = byte_value;
                    rpt_next  = report_after;
                    if (clear_first)
                    begin
                        vld_next = '0;
                        sat_next = 1'b0;
                    end
                    if (base_total == COUNT_MAX)
                    begin
                        total_next = base_total;
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        total_next = base_total + CW'(1);
                    end
                end
            end
            bee_pkg::ST_UPD:
            begin
                if (rd_f == COUNT_MAX)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    vld_next[byte_reg] = 1'b1;
                end
            end
            bee_pkg::ST_LOGN:
            begin
                s_next   = '0;
                bin_next = '0;
            end
            bee_pkg::ST_LOGN_W:
            begin
                logn_next = log_res;
            end
            bee_pkg::ST_CHK:
            begin
                opd_next = AW'(f_clamp);
                if (rd_f == '0)
                begin
                    bin_next = bin_reg + BAW'(1);
                end
            end
            bee_pkg::ST_DIFF:
            begin
                mbits_next = alu_sum[AW] ? QW'(alu_sum[DW-1:0]) : '0;
                cnt_next   = '0;
            end
            bee_pkg::ST_MUL:
            begin
                if (mbits_reg[0])
                begin
                    s_next = alu_sum[AW-1:0];
                end
                opd_next   = opd_reg << 1;
                mbits_next = mbits_reg >> 1;
                cnt_next   = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DW - 1))
                begin
                    bin_next = bin_reg + BAW'(1);
                end
            end
            bee_pkg::ST_DIVS:
            begin
                rem_next = s_reg[QW+CW-1:QW];
                cnt_next = '0;
            end
            bee_pkg::ST_DIV:
            begin
                s_next     = s_reg << 1;
                rem_next   = alu_sum[AW] ? alu_sum[CW-1:0] : div_t[CW-1:0];
                mbits_next = {mbits_reg[QW-2:0], alu_sum[AW]};
                cnt_next   = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    s_next   = '0;
                    opd_next = AW'(bee_pkg::LN2_Q32);
                    cnt_next = '0;
                end
            end
            bee_pkg::ST_LN2:
            begin
                if (mbits_reg[0])
                begin
                    s_next = alu_sum[AW-1:0];
                end
                opd_next   = opd_reg << 1;
                mbits_next = mbits_reg >> 1;
                cnt_next   = cnt_reg + CNTW'(1);
            end
            bee_pkg::ST_ROUND:
            begin
                s_next = alu_sum[AW-1:0];
            end
            bee_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ovld_next = 1'b1;
                    oent_next = (ent_hi > ENT_MAX) ? ENT_MAX[EW-1:0] : ent_hi[EW-1:0];
                    ocnt_next = total_reg;
                    osat_next = sat_reg;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bee_pkg::ST_IDLE;
            vld_reg   <= '0;
            total_reg <= '0;
            sat_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            total_reg <= total_next;
            sat_reg   <= sat_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        rpt_reg   <= rpt_next;
        s_reg     <= s_next;
        opd_reg   <= opd_next;
        mbits_reg <= mbits_next;
        rem_reg   <= rem_next;
        logn_reg  <= logn_next;
        bin_reg   <= bin_next;
        cnt_reg   <= cnt_next;
        oent_reg  <= oent_next;
        ocnt_reg  <= ocnt_next;
        osat_reg  <= osat_next;
    end

    assign out_valid       = ovld_reg;
    assign entropy_nats    = oent_reg;
    assign bytes_counted   = ocnt_reg;
    assign count_saturated = osat_reg;

    `ASSERT_NXT(a_acc_upd, clk, rst_n, in_valid && !in_stall, state_reg == bee_pkg::ST_UPD, "accepted word not followed by bin update")
    `ASSERT_IMP(a_div_rem, clk, rst_n, state_reg == bee_pkg::ST_DIV, rem_reg < total_reg, "division remainder out of range")
    `ASSERT_IMP(a_walk_total, clk, rst_n, state_reg == bee_pkg::ST_LOGN, total_reg != '0, "report walk with empty total")

endmodule
